[design/teo_pkg.sv]
`default_nettype none

package teo_pkg;

  // Fraction bits of every coordinate.
  localparam int FRAC_BITS = 16;

  // Coordinate, difference and product widths.
  localparam int CW       = 32;
  localparam int DW       = CW + 1;
  localparam int LEN2_W   = 2 * CW + 2;
  localparam int CR_W     = 2 * CW + 2;

  // Square root of the squared edge length.
  localparam int ROOT_W   = CW + 2;
  localparam int SQ_IN_W  = 2 * ROOT_W;
  localparam int SQ_REM_W = ROOT_W + 2;
  localparam int SQRT_LAT = ROOT_W;

  // Numerator |inset| * length, and the quotient k.
  localparam int PROD_W   = CW + ROOT_W;
  localparam int QW       = FRAC_BITS + ROOT_W + 1;
  localparam int HI_LSB   = QW - FRAC_BITS;
  localparam int HI_W     = PROD_W - HI_LSB;
  localparam int KW       = QW;
  localparam int DIV_LAT  = QW + 2;

  // Move products and clamps.
  localparam int KH_W     = KW - CW;
  localparam int MP_W     = KW + CW;
  localparam int D0_W     = MP_W - FRAC_BITS;
  localparam int DMAX_LOG = 40;
  localparam int DM_W     = DMAX_LOG + 1;
  localparam int SUM_W    = DM_W + 2;

  // Cycles from an accepted transaction to its result strobe.
  localparam int TEO_LATENCY = 3 + SQRT_LAT + 1 + DIV_LAT + 4;

  typedef struct packed {
    logic signed [CW-1:0] apex_x;
    logic signed [CW-1:0] apex_y;
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic signed [CW-1:0] inset;
  } teo_in_t;

  typedef struct packed {
    logic signed [CW-1:0] moved_first_x;
    logic signed [CW-1:0] moved_first_y;
    logic signed [CW-1:0] moved_second_x;
    logic signed [CW-1:0] moved_second_y;
    logic                 degenerate;
    logic                 clipped;
  } teo_out_t;

endpackage

`default_nettype wire

[design/teo_sqrt.sv]
`default_nettype none

module teo_sqrt import teo_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [LEN2_W-1:0] in_value,
  output logic                   out_valid,
  output logic [ROOT_W-1:0]      out_root
);

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
    logic [SQ_IN_W-1:0]  val;
  } sq_t;

  logic [SQRT_LAT-1:0] vld_r;
  sq_t                 st_r   [SQRT_LAT];
  sq_t                 st_nxt [SQRT_LAT];
  sq_t                 st_in;

  // One root bit per stage: bring down two value bits and try root*4+1.
  function automatic sq_t sq_step(sq_t s, logic [1:0] pair);
    logic [SQ_REM_W+1:0] r4;
    logic [SQ_REM_W+1:0] trial;
    sq_t                 o;
    r4    = {s.rem, pair};
    trial = (SQ_REM_W + 2)'({s.root, 2'b01});
    o     = s;
    if (r4 >= trial) begin
      o.rem  = SQ_REM_W'(r4 - trial);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = SQ_REM_W'(r4);
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // Stage inputs come from the previous stage register; the first stage takes in_value.
  always_comb begin
    st_in.rem  = '0;
    st_in.root = '0;
    st_in.val  = SQ_IN_W'(in_value);
    st_nxt[0]  = sq_step(st_in, st_in.val[SQ_IN_W-1 -: 2]);
    for (int i = 1; i < SQRT_LAT; i++) begin
      st_nxt[i] = sq_step(st_r[i-1], st_r[i-1].val[SQ_IN_W-1-2*i -: 2]);
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SQRT_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SQRT_LAT; i++) begin
      st_r[i] <= st_nxt[i];
    end
  end

  assign out_valid = vld_r[SQRT_LAT-1];
  assign out_root  = st_r[SQRT_LAT-1].root;

endmodule

`default_nettype wire

[design/teo_div.sv]
`default_nettype none

module teo_div import teo_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [PROD_W-1:0] in_prod,
  input  wire logic [CR_W-1:0]   in_den,
  output logic                   out_valid,
  output logic [KW-1:0]          out_k
);

  localparam logic [KW-1:0] KMAX = {1'b1, {(KW-1){1'b0}}};

  typedef struct packed {
    logic            ovf;
    logic [CR_W-1:0] rem;
    logic [QW-1:0]   q;
    logic [QW-1:0]   dbits;
    logic [CR_W-1:0] den;
  } dv_t;

  logic [DIV_LAT-1:0] vld_r;
  dv_t                dv_r   [QW+1];
  dv_t                dv_nxt [QW+1];
  logic [KW-1:0]      k_r;
  logic [KW-1:0]      k_nxt;

  // Restoring division, one quotient bit per stage.
  function automatic dv_t dv_step(dv_t s);
    logic [CR_W:0] r2;
    dv_t           o;
    r2 = {s.rem, s.dbits[QW-1]};
    o  = s;
    if (r2 >= {1'b0, s.den}) begin
      o.rem = CR_W'(r2 - {1'b0, s.den});
      o.q   = {s.q[QW-2:0], 1'b1};
    end else begin
      o.rem = CR_W'(r2);
      o.q   = {s.q[QW-2:0], 1'b0};
    end
    o.dbits = {s.dbits[QW-2:0], 1'b0};
    return o;
  endfunction

  always_comb begin
    // The numerator is in_prod shifted up by FRAC_BITS. Its bits above the
    // quotient range decide overflow; a quotient that large is clamped anyway.
    dv_nxt[0].den   = in_den;
    dv_nxt[0].rem   = CR_W'(in_prod[PROD_W-1:HI_LSB]);
    dv_nxt[0].ovf   = CR_W'(in_prod[PROD_W-1:HI_LSB]) >= in_den;
    dv_nxt[0].q     = '0;
    dv_nxt[0].dbits = {in_prod[HI_LSB-1:0], {FRAC_BITS{1'b0}}};
    for (int i = 1; i <= QW; i++) begin
      dv_nxt[i] = dv_step(dv_r[i-1]);
    end
    // Clamp the magnitude of k.
    if (dv_r[QW].ovf || (dv_r[QW].q > KMAX)) begin
      k_nxt = KMAX;
    end else begin
      k_nxt = dv_r[QW].q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DIV_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= QW; i++) begin
      dv_r[i] <= dv_nxt[i];
    end
    k_r <= k_nxt;
  end

  assign out_valid = vld_r[DIV_LAT-1];
  assign out_k     = k_r;

endmodule

`default_nettype wire

[design/triangle_edge_offset.sv]
// Triangle edge inset. Each transaction carries an apex, an edge and an inset
// distance in signed fixed point; the result carries both edge vertices slid
// along their sides toward the apex, or away from it for a negative inset,
// saturated to 32 bits, with flags for a degenerate triangle and for
// saturation. The block takes a new transaction in every cycle (busy stays
// low) and gives each result on out_data for one cycle under out_valid. The
// result passes through the square root, one root bit per stage, and the
// divider, one quotient bit per stage. The receiver cannot stall the block,
// so results must be taken when they appear.
`default_nettype none

module triangle_edge_offset import teo_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire teo_in_t  in_data,
  output logic          busy,
  output logic          out_valid,
  output teo_out_t      out_data
);

  localparam logic [D0_W-1:0] DMAX = D0_W'(1) << DMAX_LOG;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

  typedef struct packed {
    teo_in_t       p;
    logic [CW-1:0] axm;
    logic [CW-1:0] aym;
    logic [CW-1:0] bxm;
    logic [CW-1:0] bym;
    logic          neg_ba;
    logic          neg_bx;
  } s1_t;

  typedef struct packed {
    teo_in_t         p;
    logic [2*CW-1:0] ax2;
    logic [2*CW-1:0] ay2;
    logic [2*CW-1:0] pba;
    logic [2*CW-1:0] pbx;
    logic            neg_ba;
    logic            neg_bx;
  } s2_t;

  typedef struct packed {
    teo_in_t         p;
    logic [CR_W-1:0] crs;
  } sa_t;

  typedef struct packed {
    logic signed [CW-1:0] p0x;
    logic signed [CW-1:0] p0y;
    logic signed [CW-1:0] p1x;
    logic signed [CW-1:0] p1y;
    logic signed [CW-1:0] p2x;
    logic signed [CW-1:0] p2y;
    logic                 kneg;
    logic                 deg;
  } sb_t;

  typedef struct packed {
    logic [3:0][CW-1:0] base;
    logic [3:0][CW-1:0] cm;
    logic [3:0]         dneg;
    logic [KW-1:0]      k;
    logic               deg;
  } c_t;

  typedef struct packed {
    logic [3:0][CW-1:0]   base;
    logic [3:0][2*CW-1:0] pl;
    logic [3:0][KW-1:0]   ph;
    logic [3:0]           dneg;
    logic                 deg;
  } m1_t;

  typedef struct packed {
    logic [3:0][CW-1:0]   base;
    logic [3:0][DM_W-1:0] m;
    logic [3:0]           dneg;
    logic                 deg;
  } m2_t;

  function automatic logic signed [DW-1:0] sx(logic signed [CW-1:0] v);
    return {v[CW-1], v};
  endfunction

  function automatic logic [CW-1:0] mag(logic signed [DW-1:0] v);
    logic [DW-1:0] n;
    n = v[DW-1] ? -v : v;
    return n[CW-1:0];
  endfunction

  logic                  s1_vld_r, s2_vld_r, s3_vld_r, n_vld_r;
  logic                  c_vld_r, m1_vld_r, m2_vld_r, out_valid_r;
  s1_t                   s1_r, s1_nxt;
  s2_t                   s2_r, s2_nxt;
  sa_t                   s3_r, s3_nxt;
  logic [LEN2_W-1:0]     len2_r, len2_nxt;
  sa_t                   a_r [SQRT_LAT];
  logic                  sq_vld;
  logic [ROOT_W-1:0]     sq_root;
  sb_t                   nb_r, nb_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [CR_W-1:0]       crm_r, crm_nxt;
  sb_t                   b_r [DIV_LAT];
  logic                  dv_vld;
  logic [KW-1:0]         dv_k;
  c_t                    c_r, c_nxt;
  m1_t                   m1_r, m1_nxt;
  m2_t                   m2_r, m2_nxt;
  teo_out_t              out_data_r, out_data_nxt;
  logic signed [DW-1:0]  ax, ay, bx, by;
  logic [CR_W-1:0]       t_ba, t_bx;
  logic [CW-1:0]         offm;
  sb_t                   bo;
  logic signed [DW-1:0]  comp [4];
  logic [MP_W-1:0]       mp [4];
  logic [D0_W-1:0]       d0 [4];
  logic signed [SUM_W-1:0] sum [4];
  logic [3:0][CW-1:0]    res;
  logic [3:0]            sat;

  // The block never holds off a transaction.
  assign busy = 1'b0;

  // Stage 1: edge and side differences as sign and magnitude.
  always_comb begin
    ax = sx(in_data.second_x) - sx(in_data.first_x);
    ay = sx(in_data.second_y) - sx(in_data.first_y);
    bx = sx(in_data.apex_x) - sx(in_data.first_x);
    by = sx(in_data.apex_y) - sx(in_data.first_y);
    s1_nxt.p      = in_data;
    s1_nxt.axm    = mag(ax);
    s1_nxt.aym    = mag(ay);
    s1_nxt.bxm    = mag(bx);
    s1_nxt.bym    = mag(by);
    s1_nxt.neg_ba = bx[DW-1] ^ ay[DW-1];
    s1_nxt.neg_bx = by[DW-1] ^ ax[DW-1];
  end

  // Stage 2: the two squares and the two cross terms.
  always_comb begin
    s2_nxt.p      = s1_r.p;
    s2_nxt.ax2    = s1_r.axm * s1_r.axm;
    s2_nxt.ay2    = s1_r.aym * s1_r.aym;
    s2_nxt.pba    = s1_r.bxm * s1_r.aym;
    s2_nxt.pbx    = s1_r.bym * s1_r.axm;
    s2_nxt.neg_ba = s1_r.neg_ba;
    s2_nxt.neg_bx = s1_r.neg_bx;
  end

  // Stage 3: squared length and signed cross product.
  always_comb begin
    t_ba       = s2_r.neg_ba ? -{2'b00, s2_r.pba} : {2'b00, s2_r.pba};
    t_bx       = s2_r.neg_bx ? -{2'b00, s2_r.pbx} : {2'b00, s2_r.pbx};
    len2_nxt   = {2'b00, s2_r.ax2} + {2'b00, s2_r.ay2};
    s3_nxt.p   = s2_r.p;
    s3_nxt.crs = t_ba - t_bx;
  end

  teo_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_vld_r),
    .in_value  (len2_r),
    .out_valid (sq_vld),
    .out_root  (sq_root)
  );

  // Numerator |inset| * length, and the cross product magnitude.
  always_comb begin
    offm        = mag(sx(a_r[SQRT_LAT-1].p.inset));
    prod_nxt    = offm * sq_root;
    crm_nxt     = a_r[SQRT_LAT-1].crs[CR_W-1] ? -a_r[SQRT_LAT-1].crs
                                               : a_r[SQRT_LAT-1].crs;
    nb_nxt.p0x  = a_r[SQRT_LAT-1].p.apex_x;
    nb_nxt.p0y  = a_r[SQRT_LAT-1].p.apex_y;
    nb_nxt.p1x  = a_r[SQRT_LAT-1].p.first_x;
    nb_nxt.p1y  = a_r[SQRT_LAT-1].p.first_y;
    nb_nxt.p2x  = a_r[SQRT_LAT-1].p.second_x;
    nb_nxt.p2y  = a_r[SQRT_LAT-1].p.second_y;
    nb_nxt.kneg = a_r[SQRT_LAT-1].p.inset[CW-1];
    nb_nxt.deg  = (sq_root == '0) || (a_r[SQRT_LAT-1].crs == '0);
  end

  teo_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (n_vld_r),
    .in_prod   (prod_r),
    .in_den    (crm_r),
    .out_valid (dv_vld),
    .out_k     (dv_k)
  );

  // Stage C: the components that each vertex moves along.
  always_comb begin
    bo      = b_r[DIV_LAT-1];
    comp[0] = sx(bo.p0x) - sx(bo.p1x);
    comp[1] = sx(bo.p0y) - sx(bo.p1y);
    comp[2] = sx(bo.p0x) - sx(bo.p2x);
    comp[3] = sx(bo.p0y) - sx(bo.p2y);
    c_nxt.base[0] = bo.p1x;
    c_nxt.base[1] = bo.p1y;
    c_nxt.base[2] = bo.p2x;
    c_nxt.base[3] = bo.p2y;
    for (int j = 0; j < 4; j++) begin
      c_nxt.cm[j]   = mag(comp[j]);
      c_nxt.dneg[j] = bo.kneg ^ comp[j][DW-1];
    end
    c_nxt.k   = dv_k;
    c_nxt.deg = bo.deg;
  end

  // Stage M1: k times each component, as two partial products.
  always_comb begin
    m1_nxt.base = c_r.base;
    m1_nxt.dneg = c_r.dneg;
    m1_nxt.deg  = c_r.deg;
    for (int j = 0; j < 4; j++) begin
      m1_nxt.pl[j] = c_r.k[CW-1:0] * c_r.cm[j];
      m1_nxt.ph[j] = c_r.k[KW-1:CW] * c_r.cm[j];
    end
  end

  // Stage M2: join the partial products, drop fraction bits, clamp.
  always_comb begin
    m2_nxt.base = m1_r.base;
    m2_nxt.dneg = m1_r.dneg;
    m2_nxt.deg  = m1_r.deg;
    for (int j = 0; j < 4; j++) begin
      mp[j] = {m1_r.ph[j], {CW{1'b0}}} + MP_W'(m1_r.pl[j]);
      d0[j] = mp[j][MP_W-1:FRAC_BITS];
      m2_nxt.m[j] = (d0[j] > DMAX) ? DMAX[DM_W-1:0] : d0[j][DM_W-1:0];
    end
  end

  // Output stage: apply the move with saturation, or pass a degenerate
  // triangle through unchanged.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sum[j] = {{(SUM_W-CW){m2_r.base[j][CW-1]}}, m2_r.base[j]}
             + (m2_r.dneg[j] ? -{2'b00, m2_r.m[j]} : {2'b00, m2_r.m[j]});
      sat[j] = 1'b0;
      res[j] = sum[j][CW-1:0];
      if (sum[j] > SAT_HI) begin
        res[j] = SAT_HI[CW-1:0];
        sat[j] = 1'b1;
      end else if (sum[j] < SAT_LO) begin
        res[j] = SAT_LO[CW-1:0];
        sat[j] = 1'b1;
      end
      if (m2_r.deg) begin
        res[j] = m2_r.base[j];
      end
    end
    out_data_nxt.moved_first_x  = res[0];
    out_data_nxt.moved_first_y  = res[1];
    out_data_nxt.moved_second_x = res[2];
    out_data_nxt.moved_second_y = res[3];
    out_data_nxt.degenerate     = m2_r.deg;
    out_data_nxt.clipped        = !m2_r.deg && (sat != '0);
  end

  // Valid bits of the stages outside the root and divide units.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      n_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      m1_vld_r    <= 1'b0;
      m2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= start && !busy;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      n_vld_r     <= sq_vld;
      c_vld_r     <= dv_vld;
      m1_vld_r    <= c_vld_r;
      m2_vld_r    <= m1_vld_r;
      out_valid_r <= m2_vld_r;
    end
  end

  // Payload registers and the side lines that follow the root and divide.
  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    s2_r       <= s2_nxt;
    s3_r       <= s3_nxt;
    len2_r     <= len2_nxt;
    a_r[0]     <= s3_r;
    for (int i = 1; i < SQRT_LAT; i++) begin
      a_r[i] <= a_r[i-1];
    end
    nb_r       <= nb_nxt;
    prod_r     <= prod_nxt;
    crm_r      <= crm_nxt;
    b_r[0]     <= nb_r;
    for (int i = 1; i < DIV_LAT; i++) begin
      b_r[i] <= b_r[i-1];
    end
    c_r        <= c_nxt;
    m1_r       <= m1_nxt;
    m2_r       <= m2_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[design/teo_checker.sv]
`default_nettype none

module teo_checker import teo_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire teo_in_t  in_data,
  input wire logic     busy,
  input wire logic     out_valid,
  input wire teo_out_t out_data
);

  // A result strobe always traces back to a transaction a fixed time ago.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, TEO_LATENCY))
    else $error("result without a matching transaction");

  // A degenerate triangle is never reported as saturated.
  a_deg_noclip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> !out_data.clipped)
    else $error("degenerate result flagged as clipped");

  // A degenerate triangle passes its first x and second y coordinates through.
  a_deg_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.moved_first_x == $past(in_data.first_x, TEO_LATENCY) &&
      out_data.moved_second_y == $past(in_data.second_y, TEO_LATENCY))
    else $error("degenerate result changed a vertex");

  // A zero inset is not clipped and leaves first y and second x where they are.
  a_zero_inset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($past(in_data.inset, TEO_LATENCY) == '0) |->
      !out_data.clipped &&
      out_data.moved_first_y == $past(in_data.first_y, TEO_LATENCY) &&
      out_data.moved_second_x == $past(in_data.second_x, TEO_LATENCY))
    else $error("zero inset moved a vertex");

endmodule

bind triangle_edge_offset teo_checker u_teo_checker (.*);

`default_nettype wire

[tb/triangle_edge_offset_tb.sv]
`default_nettype none

module triangle_edge_offset_tb import teo_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1530;
  localparam int DRAIN_CYCLES = TEO_LATENCY + 20;

  logic     clk;
  logic     rst_n;
  logic     start;
  teo_in_t  in_data;
  logic     busy;
  logic     out_valid;
  teo_out_t out_data;

  triangle_edge_offset u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A triangle waiting to be sent, with its idle gap and an optional drain request.
  typedef struct {
    teo_in_t tri_item;
    int      gap;
    bit      drain;
  } pending_t;

  pending_t pending_q[$];
  teo_out_t moved_q[$];
  int       error_count;
  bit       stim_done;
  bit       all_sent;

  initial begin
    clk = 1'b0;
  end
  always #5 clk = ~clk;

  // Saturate a wide sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] s, inout bit clip);
    if (s > 64'sh7FFFFFFF) begin
      clip = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (s < -64'sh80000000) begin
      clip = 1'b1;
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  // Move one coordinate by k times its side component, truncated toward zero.
  function automatic logic signed [31:0] slide(input logic signed [32:0] base,
                                               input logic signed [32:0] comp,
                                               input bit kneg,
                                               input logic [63:0] kmag,
                                               inout bit clip);
    logic [127:0] prod;
    logic [127:0] m;
    logic [32:0]  cmag;
    logic signed [63:0] d;
    cmag = comp[32] ? -comp : comp;
    prod = ({64'd0, kmag} * {95'd0, cmag}) >> FRAC_BITS;
    m = (prod > (128'd1 << 40)) ? (128'd1 << 40) : prod;
    d = (kneg != comp[32]) ? -$signed({1'b0, m[62:0]}) : $signed({1'b0, m[62:0]});
    return sat32($signed({{31{base[32]}}, base}) + d, clip);
  endfunction

  // Expected moved vertices and flags for one triangle.
  function automatic teo_out_t inset_edge(input teo_in_t t);
    logic signed [32:0]  ax, ay, bx, by, cx, cy;
    logic signed [127:0] cr;
    logic [127:0] len2, num, k, lsq;
    logic [63:0]  len, cand, kmag;
    logic [31:0]  offmag;
    teo_out_t r;
    bit clip;
    clip = 1'b0;
    ax = $signed({t.second_x[31], t.second_x}) - $signed({t.first_x[31], t.first_x});
    ay = $signed({t.second_y[31], t.second_y}) - $signed({t.first_y[31], t.first_y});
    bx = $signed({t.apex_x[31], t.apex_x}) - $signed({t.first_x[31], t.first_x});
    by = $signed({t.apex_y[31], t.apex_y}) - $signed({t.first_y[31], t.first_y});
    cx = $signed({t.apex_x[31], t.apex_x}) - $signed({t.second_x[31], t.second_x});
    cy = $signed({t.apex_y[31], t.apex_y}) - $signed({t.second_y[31], t.second_y});
    len2 = $unsigned(128'(ax) * 128'(ax)) + $unsigned(128'(ay) * 128'(ay));
    cr = 128'(bx) * 128'(ay) - 128'(by) * 128'(ax);
    if (cr < 0) cr = -cr;
    if (len2 == 0 || cr == 0) begin
      r.moved_first_x = t.first_x;
      r.moved_first_y = t.first_y;
      r.moved_second_x = t.second_x;
      r.moved_second_y = t.second_y;
      r.degenerate = 1'b1;
      r.clipped = 1'b0;
      return r;
    end
    // Integer square root, one bit at a time.
    len = 0;
    for (int b = 33; b >= 0; b--) begin
      cand = len | (64'd1 << b);
      lsq = {64'd0, cand} * {64'd0, cand};
      if (len2 >= lsq) len = cand;
    end
    offmag = t.inset[31] ? -t.inset : t.inset;
    num = ({96'd0, offmag} * {64'd0, len}) << FRAC_BITS;
    k = num / $unsigned(cr);
    kmag = (k > (128'd1 << (FRAC_BITS + 34))) ? (64'd1 << (FRAC_BITS + 34)) : k[63:0];
    r.moved_first_x = slide({t.first_x[31], t.first_x}, bx, t.inset[31], kmag, clip);
    r.moved_first_y = slide({t.first_y[31], t.first_y}, by, t.inset[31], kmag, clip);
    r.moved_second_x = slide({t.second_x[31], t.second_x}, cx, t.inset[31], kmag, clip);
    r.moved_second_y = slide({t.second_y[31], t.second_y}, cy, t.inset[31], kmag, clip);
    r.degenerate = 1'b0;
    r.clipped = clip;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                     : 32'h8000_0000 + $urandom_range(0, 255);
      default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  task automatic queue_tri(input logic [31:0] x0, y0, x1, y1, x2, y2, off, input bit drain = 0);
    pending_t p;
    p.tri_item = '{x0, y0, x1, y1, x2, y2, off};
    p.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    p.drain = drain;
    pending_q.insert(pending_q.size(), p);
  endtask

  // Directed triangles first, then random ones.
  initial begin
    logic [31:0] v[7];
    int mode;
    queue_tri(0, 32'h000A_0000, 0, 0, 32'h000A_0000, 0, 32'h0001_0000);
    queue_tri(0, 32'h000A_0000, 0, 0, 32'h000A_0000, 0, 32'hFFFF_0000);
    queue_tri(0, 32'h000A_0000, 0, 0, 32'h000A_0000, 0, 0);
    queue_tri(5, 7, 3, 3, 3, 3, 32'h0001_0000);                  // coincident vertices
    queue_tri(2, 2, 0, 0, 1, 1, 32'h0001_0000);                  // collinear
    queue_tri(0, 32'h7FFF_FFFF, 0, 0, 32'h0000_0001, 0, 32'h7FFF_FFFF);
    queue_tri(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    queue_tri(1, 1, 0, 0, 1, 0, 1);
    queue_tri(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    queue_tri(0, 32'h0010_0000, 32'hFFF0_0000, 0, 32'h0010_0000, 0, 32'h0008_0000, 1);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      mode = $urandom_range(0, 3);
      foreach (v[j]) v[j] = rand_coord(mode);
      // Some collinear and coincident triangles among the random ones.
      if ($urandom_range(0, 19) == 0) begin
        v[4] = v[2];
        v[5] = v[3];
      end else if ($urandom_range(0, 19) == 0) begin
        v[0] = v[2] + 2 * (v[4] - v[2]);
        v[1] = v[3] + 2 * (v[5] - v[3]);
      end
      if ($urandom_range(0, 3) == 0) v[6] = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      if ($urandom_range(0, 49) == 0) v[6] = 0;
      queue_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], i == NUM_RANDOM / 2);
    end
    stim_done = 1'b1;
  end

  // Driver: one triangle per accepted transaction, idle gaps between them.
  initial begin
    start = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    error_count = 0;
    all_sent = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  int  gap_left;
  bit  holding;
  bit  draining;
  initial begin
    gap_left = 0;
    holding = 1'b0;
    draining = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        moved_q.insert(moved_q.size(), inset_edge(in_data));
        holding = 1'b0;
      end
      if (!(holding && !(start && !busy) && start)) begin
        if (!holding) begin
          if (draining) begin
            if (moved_q.size() == 0) draining = 1'b0;
            start <= 1'b0;
          end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
          end else if (pending_q.size() > 0) begin
            if (pending_q[0].drain && moved_q.size() != 0) begin
              draining = 1'b1;
              start <= 1'b0;
            end else begin
              pending_t p;
              p = pending_q.pop_front();
              in_data <= p.tri_item;
              start <= 1'b1;
              gap_left = p.gap;
              holding = 1'b1;
            end
          end else begin
            start <= 1'b0;
            if (stim_done) all_sent = 1'b1;
          end
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (moved_q.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        teo_out_t e;
        e = moved_q.pop_front();
        if (out_data.moved_first_x !== e.moved_first_x) begin
          $error("moved_first_x exp %h got %h", e.moved_first_x, out_data.moved_first_x);
          error_count++;
        end
        if (out_data.moved_first_y !== e.moved_first_y) begin
          $error("moved_first_y exp %h got %h", e.moved_first_y, out_data.moved_first_y);
          error_count++;
        end
        if (out_data.moved_second_x !== e.moved_second_x) begin
          $error("moved_second_x exp %h got %h", e.moved_second_x, out_data.moved_second_x);
          error_count++;
        end
        if (out_data.moved_second_y !== e.moved_second_y) begin
          $error("moved_second_y exp %h got %h", e.moved_second_y, out_data.moved_second_y);
          error_count++;
        end
        if (out_data.degenerate !== e.degenerate) begin
          $error("degenerate exp %b got %b", e.degenerate, out_data.degenerate);
          error_count++;
        end
        if (out_data.clipped !== e.clipped) begin
          $error("clipped exp %b got %b", e.clipped, out_data.clipped);
          error_count++;
        end
      end
    end
  end

  // End of run: drain, settle, then report.
  initial begin
    wait (all_sent);
    while (moved_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && moved_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(2_000_000ns);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
design/teo_pkg.sv
design/teo_sqrt.sv
design/teo_div.sv
design/triangle_edge_offset.sv
design/teo_checker.sv
tb/triangle_edge_offset_tb.sv
